// ----- hdl/tcw_pkg.sv -----
// ============================================================================
// tcw_pkg
// Shared widths, codes and types of the text console writer.
// ============================================================================
package tcw_pkg;

    // Field widths
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int IDX_W      = 11;
    localparam int POS_W      = 11;
    // Wide enough for row * columns + column at the largest geometry
    localparam int POS_FULL_W = 14;

    // Default geometry
    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    // Byte codes and reset value
    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_BYTE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

    // Command codes
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PUT,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/tcw_req_if.sv -----
// ============================================================================
// tcw_req_if
// Request channel: put or read command with valid/ready.
// ============================================================================
interface tcw_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [tcw_pkg::CHAR_W-1:0] character;
    logic [tcw_pkg::IDX_W-1:0]  cell_index;
    logic                       last_in_string;

    modport source (output valid, command, character, cell_index, last_in_string,
                    input ready);
    modport sink   (input valid, command, character, cell_index, last_in_string,
                    output ready);
endinterface

// ----- hdl/tcw_rsp_if.sv -----
// ============================================================================
// tcw_rsp_if
// Response channel: cursor position, read data and string flag.
// ============================================================================
interface tcw_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::POS_W-1:0]  cursor_position;
    logic [tcw_pkg::CELL_W-1:0] read_data;
    logic                       string_done;

    modport source (output valid, cursor_position, read_data, string_done,
                    input ready);
    modport sink   (input valid, cursor_position, read_data, string_done,
                    output ready);
endinterface

// ----- hdl/tcw_cfg_if.sv -----
// ============================================================================
// tcw_cfg_if
// Configuration write channel for the attribute register.
// ============================================================================
interface tcw_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::ATTR_W-1:0] cell_attribute;

    modport source (output valid, cell_attribute, input ready);
    modport sink   (input valid, cell_attribute, output ready);
endinterface

// ----- hdl/tcw_screen_ram.sv -----
// ============================================================================
// tcw_screen_ram
// Screen cell memory: one write port, one read port, registered read data.
// ============================================================================
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tcw_ctrl.sv -----
// ============================================================================
// tcw_ctrl
// Console sequencer: cursor, attribute register, clear/scroll sweeps over
// the screen memory and the response register.
// ============================================================================
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
    parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    tcw_req_if.sink                    request,
    tcw_rsp_if.source                  response,
    tcw_cfg_if.sink                    cfg,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [ADDR_W-1:0]          mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0] mem_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    tcw_pkg::state_t             state_reg, state_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [ADDR_W-1:0]           cnt_reg, cnt_next;
    logic [tcw_pkg::ATTR_W-1:0]  attr_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        cmd_reg, cmd_next;
    logic                        last_reg, last_next;
    logic                        zero_reg, zero_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tcw_pkg::POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [tcw_pkg::CELL_W-1:0]  out_data_reg, out_data_next;
    logic                        out_done_reg, out_done_next;

    logic [tcw_pkg::POS_FULL_W-1:0] pos_full;
    logic [tcw_pkg::CELL_W-1:0]     blank_cell;
    logic [tcw_pkg::CHAR_W-1:0]     act_char;
    logic [31:0]                    idx_ext;
    logic                           idx_in_range;
    logic                           at_end_col;
    logic                           at_last_row;
    logic                           do_put;

    // Cursor address and helpers
    assign pos_full     = tcw_pkg::POS_FULL_W'(row_reg) * tcw_pkg::POS_FULL_W'(COLUMNS)
                        + tcw_pkg::POS_FULL_W'(col_reg);
    assign blank_cell   = {attr_reg, tcw_pkg::BLANK_BYTE};
    assign act_char     = (state_reg == tcw_pkg::ST_IDLE) ? request.character : char_reg;
    assign idx_ext      = 32'(request.cell_index);
    assign idx_in_range = idx_ext < 32'(CELL_COUNT);
    assign at_end_col   = col_reg == COL_W'(COLUMNS - 1);
    assign at_last_row  = row_reg == ROW_W'(ROWS - 1);

    // Handshakes
    assign request.ready            = state_reg == tcw_pkg::ST_IDLE;
    assign cfg.ready                = 1'b1;
    assign response.valid           = out_valid_reg;
    assign response.cursor_position = out_pos_reg;
    assign response.read_data       = out_data_reg;
    assign response.string_done     = out_done_reg;

    // Next state and memory control
    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        cnt_next      = cnt_reg;
        char_next     = char_reg;
        cmd_next      = cmd_reg;
        last_next     = last_reg;
        zero_next     = zero_reg;
        out_pos_next  = out_pos_reg;
        out_data_next = out_data_reg;
        out_done_next = out_done_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_full[ADDR_W-1:0];
        mem_wdata     = {attr_reg, act_char};
        mem_re        = 1'b0;
        mem_raddr     = idx_ext[ADDR_W-1:0];
        do_put        = 1'b0;

        out_valid_next = out_valid_reg;
        if (response.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next  = request.command;
                    last_next = request.last_in_string;
                    char_next = request.character;
                    if (request.command == tcw_pkg::CMD_READ)
                    begin
                        mem_re     = idx_in_range;
                        zero_next  = !idx_in_range;
                        state_next = tcw_pkg::ST_DONE;
                    end
                    else if (col_reg == '0 && row_reg == '0)
                    begin
                        cnt_next   = '0;
                        state_next = tcw_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        do_put = 1'b1;
                    end
                end
            end

            // Fill the whole screen with blanks
            tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = blank_cell;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = tcw_pkg::ST_PUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Held byte after the clear
            tcw_pkg::ST_PUT:
            begin
                do_put = 1'b1;
            end

            // Copy row r+1 to row r: read ahead, write the previous read
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg != ADDR_W'(MOVE_COUNT))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + ADDR_W'(COLUMNS);
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg - 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (cnt_reg == ADDR_W'(MOVE_COUNT))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Blank the bottom row
            tcw_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(MOVE_COUNT) + cnt_reg;
                mem_wdata = blank_cell;
                if (cnt_reg == ADDR_W'(COLUMNS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Hand the result to the response register
            tcw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_full[tcw_pkg::POS_W-1:0];
                    out_done_next  = last_reg;
                    if (cmd_reg == tcw_pkg::CMD_READ && !zero_reg)
                    begin
                        out_data_next = mem_rdata;
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        // Store a byte or advance to the next line
        if (do_put)
        begin
            if (act_char != tcw_pkg::NEWLINE_BYTE)
            begin
                mem_we = 1'b1;
            end
            if (act_char == tcw_pkg::NEWLINE_BYTE || at_end_col)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_SCROLL;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                state_next = tcw_pkg::ST_DONE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                attr_reg <= cfg.cell_attribute;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        cmd_reg      <= cmd_next;
        last_reg     <= last_next;
        zero_reg     <= zero_next;
        out_pos_reg  <= out_pos_next;
        out_data_reg <= out_data_next;
        out_done_reg <= out_done_next;
    end

endmodule

// ----- hdl/text_console_writer.sv -----
// ============================================================================
// text_console_writer
// Text-mode console: put and read commands over a ROWS x COLUMNS screen
// memory, one result per command.
// ============================================================================
// A read or a plain put passes through the DONE state into the response register,
// which may stall on back-pressure; a new request is taken only back in IDLE.
// The first put after reset first clears the screen, then stores the byte.
// A put that moves past the last row first runs the scroll copy and bottom-row
// blanking; the copy reads ahead on the read port and writes on the write port.
// Reset puts the cursor at the origin and the attribute at 7; the first put clears.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   request,
    tcw_rsp_if.source response,
    tcw_cfg_if.sink   cfg
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    // Sequencer
    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .response  (response),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Screen memory
    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ----- bench/text_console_writer_checker.sv -----
// ============================================================================
// text_console_writer_checker
// Watches the request, response and attribute channels of the console
// writer. It keeps its own screen, cursor and attribute, works out the reply
// for every request transfer and compares each response transfer against the
// oldest reply still awaited.
// ============================================================================
module text_console_writer_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEFAULT_COLUMNS,
    parameter int ROWS    = DEFAULT_ROWS
) (
    input  logic clk,
    input  logic rst_n,
    tcw_req_if   request,
    tcw_rsp_if   response,
    tcw_cfg_if   cfg,
    output int   failures,
    output int   pending
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] read_data;
        logic              string_done;
    } console_reply_t;

    // Shadow console state
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cursor_col;
    int unsigned       cursor_row;
    logic [ATTR_W-1:0] attribute;

    console_reply_t awaited_replies [$];
    console_reply_t oldest;
    int             mismatch_count;

    // Newline or row wrap; past the bottom row the screen scrolls up by one
    task automatic advance_line();
        cursor_col = 0;
        cursor_row++;
        if (cursor_row >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            cursor_row = ROWS - 1;
            for (int i = 0; i < COLUMNS; i++)
                screen[cursor_row * COLUMNS + i] = {attribute, BLANK_BYTE};
        end
    endtask

    // Put one byte; a put at the origin blanks the screen first
    task automatic store_char(logic [CHAR_W-1:0] ch);
        if (cursor_col == 0 && cursor_row == 0)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = {attribute, BLANK_BYTE};
        end
        if (ch == NEWLINE_BYTE)
            advance_line();
        else
        begin
            screen[cursor_row * COLUMNS + cursor_col] = {attribute, ch};
            cursor_col++;
            if (cursor_col >= COLUMNS)
                advance_line();
        end
    endtask

    // Apply one request and queue the reply it must produce
    task automatic model_request(logic cmd, logic [CHAR_W-1:0] ch,
                                 logic [IDX_W-1:0] idx, logic last);
        console_reply_t reply;
        reply.read_data = '0;
        if (cmd == CMD_PUT)
            store_char(ch);
        else if (idx < CELLS)
            reply.read_data = screen[idx];
        reply.cursor_position = POS_W'(cursor_row * COLUMNS + cursor_col);
        reply.string_done     = last;
        awaited_replies.push_back(reply);
    endtask

    // Per-edge bookkeeping: attribute writes, response checks, new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col     = 0;
            cursor_row     = 0;
            attribute      = ATTR_RESET;
            mismatch_count = 0;
            awaited_replies.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                attribute = cfg.cell_attribute;

            if (response.valid && response.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("response transfer with no reply awaited");
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_replies.pop_front();
                    if (response.cursor_position !== oldest.cursor_position)
                    begin
                        $error("cursor_position: expected %0d, actual %0d",
                               oldest.cursor_position, response.cursor_position);
                        mismatch_count++;
                    end
                    if (response.read_data !== oldest.read_data)
                    begin
                        $error("read_data: expected 0x%04h, actual 0x%04h",
                               oldest.read_data, response.read_data);
                        mismatch_count++;
                    end
                    if (response.string_done !== oldest.string_done)
                    begin
                        $error("string_done: expected %0b, actual %0b",
                               oldest.string_done, response.string_done);
                        mismatch_count++;
                    end
                end
            end

            if (request.valid && request.ready)
                model_request(request.command, request.character,
                              request.cell_index, request.last_in_string);

            failures <= mismatch_count;
            pending  <= awaited_replies.size();
        end
    end

endmodule

// ----- bench/text_console_writer_tb.sv -----
// ============================================================================
// text_console_writer_tb
// Drives put and read commands and attribute writes into the console writer
// with random idling on both sides. A short directed burst covers the first
// clear, newline at the origin, byte extremes and out-of-range reads; random
// strings then exercise wrapping and scrolling under several attributes.
// ============================================================================
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int     COLUMNS      = DEFAULT_COLUMNS;
    localparam int     ROWS         = DEFAULT_ROWS;
    localparam int     CELLS        = COLUMNS * ROWS;
    localparam int     CLK_PERIOD   = 10;
    localparam int     PHASES       = 6;
    localparam int     PHASE_ITEMS  = 130;
    localparam int     HOLD_CYCLES  = 200;
    // Long enough for a full clear or scroll to finish
    localparam int     SETTLE_CYCLES = CELLS + COLUMNS + 16;
    localparam longint LIMIT_CYCLES  = 8_000_000;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   phase_items;
    bit   no_idle;
    bit   hold_replies;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();
    tcw_cfg_if cfg_ch ();

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .cfg      (cfg_ch)
    );

    text_console_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending)
    );

    // Clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("text_console_writer_tb: FAIL");
        $finish;
    end

    // Response side: random back-pressure, steady stretch, one long hold-off
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_replies)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_replies = 1'b0;
            end
            else if (no_idle || !rst_n)
                rsp_ch.ready = rst_n;
            else
                rsp_ch.ready = ($urandom_range(0, 99) >= 26);
        end
    end

    // One request transfer, with random idle cycles ahead of it
    task automatic send_item(logic cmd, logic [CHAR_W-1:0] ch,
                             logic [IDX_W-1:0] idx, logic last);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                req_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        req_ch.valid          = 1'b1;
        req_ch.command        = cmd;
        req_ch.character      = ch;
        req_ch.cell_index     = idx;
        req_ch.last_in_string = last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        phase_items++;
    endtask

    // Attribute write; only issued while the block is idle
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_ch.valid          = 1'b1;
        cfg_ch.cell_attribute = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Read address: mostly the bottom rows, where text lands after scrolling
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 40)
            return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        return IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
    endfunction

    // One string of puts: usually short, sometimes a long line that wraps
    task automatic send_string();
        int               len;
        bit               long_line;
        logic [CHAR_W-1:0] ch;
        long_line = ($urandom_range(0, 9) == 0);
        len = long_line ? $urandom_range(70, 170) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            if (!long_line && $urandom_range(0, 7) == 0)
                ch = NEWLINE_BYTE;
            else if ($urandom_range(0, 99) < 85)
                ch = CHAR_W'($urandom_range(32, 126));
            else
                ch = CHAR_W'($urandom_range(0, 255));
            send_item(CMD_PUT, ch, IDX_W'($urandom_range(0, (1 << IDX_W) - 1)),
                      (i == len - 1));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [ATTR_W-1:0] attr_value;
        bit                paused;

        rst_n        = 1'b0;
        no_idle      = 1'b0;
        hold_replies = 1'b0;
        phase_items  = 0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_PUT;
        req_ch.character      = '0;
        req_ch.cell_index     = '0;
        req_ch.last_in_string = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.cell_attribute = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: newline at the origin clears first, then byte extremes
        write_attribute(8'h00);
        send_item(CMD_PUT, NEWLINE_BYTE, '0, 1'b0);
        send_item(CMD_PUT, 8'h00, '0, 1'b0);
        send_item(CMD_PUT, 8'hFF, '1, 1'b0);
        send_item(CMD_PUT, 8'h41, 11'h555, 1'b1);
        send_item(CMD_PUT, BLANK_BYTE, 11'h2AA, 1'b0);
        send_item(CMD_PUT, 8'h80, '0, 1'b0);
        send_item(CMD_PUT, 8'h7F, '0, 1'b0);
        send_item(CMD_PUT, NEWLINE_BYTE, '0, 1'b1);
        // Reads: blank cell, stored bytes, last cell, out of range
        send_item(CMD_READ, '0, 11'd0, 1'b0);
        send_item(CMD_READ, '1, 11'd80, 1'b1);
        send_item(CMD_READ, 8'h55, 11'd81, 1'b0);
        send_item(CMD_READ, 8'hAA, 11'd82, 1'b1);
        send_item(CMD_READ, '0, 11'd85, 1'b0);
        send_item(CMD_READ, '0, IDX_W'(CELLS - 1), 1'b0);
        send_item(CMD_READ, '0, IDX_W'(CELLS), 1'b1);
        send_item(CMD_READ, '0, '1, 1'b0);
        send_item(CMD_PUT, 8'h0D, '0, 1'b0);
        send_item(CMD_READ, '0, 11'd160, 1'b0);
        req_ch.valid = 1'b0;

        // Random phases, each under its own attribute
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (p)
                0:       attr_value = 8'hFF;
                2:       attr_value = ATTR_RESET;
                default: attr_value = ATTR_W'($urandom_range(0, 255));
            endcase
            write_attribute(attr_value);

            phase_items  = 0;
            paused       = 1'b0;
            no_idle      = (p == 3);
            hold_replies = (p == 1);
            while (phase_items < PHASE_ITEMS)
            begin
                // Sender waits out every reply once, mid-phase
                if (p == 4 && !paused && phase_items >= PHASE_ITEMS / 2)
                begin
                    req_ch.valid = 1'b0;
                    wait_drained();
                    paused = 1'b1;
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                        send_string();
                    7, 8:
                        repeat ($urandom_range(1, 3))
                            send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)),
                                      pick_index(), 1'($urandom_range(0, 1)));
                    default:
                        send_item(1'($urandom_range(0, 1)),
                                  CHAR_W'($urandom_range(0, 255)),
                                  pick_index(), 1'($urandom_range(0, 1)));
                endcase
            end
            req_ch.valid = 1'b0;
            no_idle      = 1'b0;
        end

        // Drain and let any trailing memory walk finish
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("text_console_writer_tb: PASS");
        else
            $display("text_console_writer_tb: FAIL");
        $finish;
    end

endmodule
